/* src/assert_macros.svh */
// Assertion macros used by the top module of the matrix inverse unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/m3i_pkg.sv */
// Types, widths and index tables shared by the matrix inverse unit.
package m3i_pkg;

   localparam int DATA_W         = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int FIFO_DEPTH_DEF = 4;

   localparam int PROD_W = 2 * DATA_W;
   localparam int COF_W  = 2 * DATA_W + 1;
   localparam int DET_W  = 3 * DATA_W + 1;
   localparam int QUO_W  = DATA_W + 2;
   localparam int REM_W  = DET_W + 1;

   // Operand pairs of the eighteen products; cofactor i is product 2i minus product 2i+1.
   localparam int PROD_IDX [18][2] = '{
      '{4, 8}, '{5, 7},
      '{2, 7}, '{1, 8},
      '{1, 5}, '{2, 4},
      '{5, 6}, '{3, 8},
      '{0, 8}, '{2, 6},
      '{2, 3}, '{0, 5},
      '{3, 7}, '{4, 6},
      '{1, 6}, '{0, 7},
      '{0, 4}, '{1, 3}
   };

   typedef logic [DATA_W-1:0] elem_type;

   typedef struct packed {
      elem_type a00;
      elem_type a01;
      elem_type a02;
      elem_type a10;
      elem_type a11;
      elem_type a12;
      elem_type a20;
      elem_type a21;
      elem_type a22;
   } req_type;

   typedef struct packed {
      elem_type b00;
      elem_type b01;
      elem_type b02;
      elem_type b10;
      elem_type b11;
      elem_type b12;
      elem_type b20;
      elem_type b21;
      elem_type b22;
      logic     singular;
   } rsp_type;

   typedef struct packed {
      logic [2:0][DATA_W-1:0] arow;
      logic [8:0][COF_W-1:0]  cof;
   } work_type;

   typedef struct packed {
      logic             neg;
      logic             ovf;
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] nlo;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

endpackage

/* src/m3i_front.sv */
// Front end: takes matrix beats and forms the nine cofactors in two stages.
module m3i_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  m3i_pkg::req_type   req_data,
   input  logic               push_ok,
   output logic               work_valid,
   output m3i_pkg::work_type  work_data
);

   localparam int W  = m3i_pkg::DATA_W;
   localparam int PW = m3i_pkg::PROD_W;

   logic [8:0][W-1:0]       elem;
   logic signed [PW-1:0]    prod_in [0:17];
   logic signed [PW-1:0]    prod_ff [0:17];
   logic [2:0][W-1:0]       arow_ff;
   m3i_pkg::work_type       work_in;
   m3i_pkg::work_type       work_ff;
   logic                    v1_ff;
   logic                    v2_ff;
   logic                    adv;

   assign elem[0] = req_data.a00;
   assign elem[1] = req_data.a01;
   assign elem[2] = req_data.a02;
   assign elem[3] = req_data.a10;
   assign elem[4] = req_data.a11;
   assign elem[5] = req_data.a12;
   assign elem[6] = req_data.a20;
   assign elem[7] = req_data.a21;
   assign elem[8] = req_data.a22;

   assign adv       = !v2_ff || push_ok;
   assign req_stall = !adv;

   for (genvar p = 0; p < 18; p++) begin : g_prod
      assign prod_in[p] = $signed(elem[m3i_pkg::PROD_IDX[p][0]])
                        * $signed(elem[m3i_pkg::PROD_IDX[p][1]]);
   end

   assign work_in.arow = arow_ff;
   for (genvar i = 0; i < 9; i++) begin : g_cof
      assign work_in.cof[i] = $signed({prod_ff[2*i][PW-1], prod_ff[2*i]})
                            - $signed({prod_ff[2*i+1][PW-1], prod_ff[2*i+1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         arow_ff <= elem[2:0];
         work_ff <= work_in;
      end
   end

   assign work_valid = v2_ff;
   assign work_data  = work_ff;

endmodule

/* src/m3i_fifo.sv */
// Short queue that decouples the cofactor front end from the divide back end.
module m3i_fifo #(
   parameter int DEPTH = m3i_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  m3i_pkg::work_type  push_data,
   input  logic               pop,
   output m3i_pkg::work_type  pop_data,
   output logic               full,
   output logic               empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   m3i_pkg::work_type  mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);

endmodule

/* src/m3i_back.sv */
// Back end: determinant, pipelined restoring divide, rounding and saturation.
module m3i_back #(
   parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  m3i_pkg::work_type  in_data,
   output logic               in_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output m3i_pkg::rsp_type   rsp_data
);

   localparam int W     = m3i_pkg::DATA_W;
   localparam int CW    = m3i_pkg::COF_W;
   localparam int DW    = m3i_pkg::DET_W;
   localparam int QB    = m3i_pkg::QUO_W;
   localparam int RW    = m3i_pkg::REM_W;
   localparam int LO_W  = W + 1;
   localparam int NW    = CW + 2 * FRAC_BITS + 1;
   localparam int TOP_W = NW - QB;
   localparam logic [QB-1:0] LIM = {{(QB-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

   logic                       adv;
   logic                       v1_ff, v2_ff, v3_ff;
   logic [8:0][CW-1:0]         cof1_ff, cof2_ff, cof3_ff;
   logic signed [2*W+1:0]      plo_in [0:2];
   logic signed [2*W+1:0]      plo_ff [0:2];
   logic signed [2*W-1:0]      phi_in [0:2];
   logic signed [2*W-1:0]      phi_ff [0:2];
   logic signed [DW-1:0]       term_in [0:2];
   logic signed [DW-1:0]       term_ff [0:2];
   logic signed [DW-1:0]       det_in;
   logic signed [DW-1:0]       det_ff;
   logic [DW-1:0]              dmag_in;
   logic                       sing_in;

   m3i_pkg::div_lane_type [8:0] lane_in [0:QB];
   m3i_pkg::div_lane_type [8:0] lane_ff [0:QB];
   logic [DW-1:0]              dmag_ff [0:QB];
   logic                       sing_ff [0:QB];
   logic                       vd_ff   [0:QB];

   logic [8:0][W-1:0]          b;
   m3i_pkg::rsp_type           rsp_in;
   m3i_pkg::rsp_type           rsp_ff;
   logic                       rsp_valid_ff;

   assign adv    = !(rsp_valid_ff && rsp_stall);
   assign in_pop = in_valid && adv;

   for (genvar j = 0; j < 3; j++) begin : g_det
      logic signed [W-1:0]   a_s;
      logic signed [W+1:0]   lo_s;
      logic signed [W-1:0]   hi_s;
      assign a_s  = $signed(in_data.arow[j]);
      assign lo_s = $signed({1'b0, in_data.cof[3*j][LO_W-1:0]});
      assign hi_s = $signed(in_data.cof[3*j][CW-1:LO_W]);
      assign plo_in[j] = a_s * lo_s;
      assign phi_in[j] = a_s * hi_s;
      assign term_in[j] = ($signed({{(DW-2*W){phi_ff[j][2*W-1]}}, phi_ff[j]}) <<< LO_W)
                        + $signed({{(DW-2*W-2){plo_ff[j][2*W+1]}}, plo_ff[j]});
   end

   assign det_in  = term_ff[0] + term_ff[1] + term_ff[2];
   assign dmag_in = det_ff[DW-1] ? (~det_ff + 1'b1) : det_ff;
   assign sing_in = (det_ff == '0);

   for (genvar i = 0; i < 9; i++) begin : g_lane
      logic [CW-1:0]    cmag;
      logic [NW-1:0]    num;
      logic [TOP_W-1:0] top;
      assign cmag = cof3_ff[i][CW-1] ? (~cof3_ff[i] + 1'b1) : cof3_ff[i];
      assign num  = {cmag, {(2*FRAC_BITS+1){1'b0}}};
      assign top  = num[NW-1:QB];
      assign lane_in[0][i].neg = cof3_ff[i][CW-1] ^ det_ff[DW-1];
      assign lane_in[0][i].ovf = (top >= dmag_in);
      assign lane_in[0][i].rem = RW'(top);
      assign lane_in[0][i].nlo = num[QB-1:0];
      assign lane_in[0][i].quo = '0;

      for (genvar s = 0; s < QB; s++) begin : g_step
         logic [RW-1:0] shifted;
         logic          ge;
         assign shifted = {lane_ff[s][i].rem[RW-2:0], lane_ff[s][i].nlo[QB-1]};
         assign ge      = (shifted >= {1'b0, dmag_ff[s]});
         assign lane_in[s+1][i].neg = lane_ff[s][i].neg;
         assign lane_in[s+1][i].ovf = lane_ff[s][i].ovf;
         assign lane_in[s+1][i].rem = ge ? (shifted - {1'b0, dmag_ff[s]}) : shifted;
         assign lane_in[s+1][i].nlo = {lane_ff[s][i].nlo[QB-2:0], 1'b0};
         assign lane_in[s+1][i].quo = {lane_ff[s][i].quo[QB-2:0], ge};
      end

      logic [QB:0]   qr;
      logic [QB-1:0] q;
      logic [QB-1:0] negq;
      assign qr   = {1'b0, lane_ff[QB][i].quo} + 1'b1;
      assign q    = qr[QB:1];
      assign negq = ~q + 1'b1;

      always_comb begin
         if (sing_ff[QB]) begin
            b[i] = '0;
         end else if (lane_ff[QB][i].neg) begin
            if (lane_ff[QB][i].ovf || q > LIM) begin
               b[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
               b[i] = negq[W-1:0];
            end
         end else begin
            if (lane_ff[QB][i].ovf || q >= LIM) begin
               b[i] = {1'b0, {(W-1){1'b1}}};
            end else begin
               b[i] = q[W-1:0];
            end
         end
      end
   end

   assign rsp_in.b00      = b[0];
   assign rsp_in.b01      = b[1];
   assign rsp_in.b02      = b[2];
   assign rsp_in.b10      = b[3];
   assign rsp_in.b11      = b[4];
   assign rsp_in.b12      = b[5];
   assign rsp_in.b20      = b[6];
   assign rsp_in.b21      = b[7];
   assign rsp_in.b22      = b[8];
   assign rsp_in.singular = sing_ff[QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s <= QB; s++) begin
            vd_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff    <= in_valid;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         vd_ff[0] <= v3_ff;
         for (int s = 0; s < QB; s++) begin
            vd_ff[s+1] <= vd_ff[s];
         end
         rsp_valid_ff <= vd_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         plo_ff     <= plo_in;
         phi_ff     <= phi_in;
         cof1_ff    <= in_data.cof;
         term_ff    <= term_in;
         cof2_ff    <= cof1_ff;
         det_ff     <= det_in;
         cof3_ff    <= cof2_ff;
         lane_ff[0] <= lane_in[0];
         dmag_ff[0] <= dmag_in;
         sing_ff[0] <= sing_in;
         for (int s = 0; s < QB; s++) begin
            lane_ff[s+1] <= lane_in[s+1];
            dmag_ff[s+1] <= dmag_ff[s];
            sing_ff[s+1] <= sing_ff[s];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/matrix3_inverse_unit.sv */
// 3x3 matrix inverse in signed fixed point, one matrix beat in and one result beat out.
// From the accepting edge to rsp_valid a matrix passes through two cofactor stages, one
// queue slot, three determinant stages, a DATA_W + 3 stage divide and the output register,
// the first cofactor stage loading at the accepting edge. Throughput is one matrix per
// cycle while rsp_stall stays low; the divide array is fully pipelined per quotient bit.
// Synchronous active-high reset clears all valid flags and queue pointers; data is not reset.
`include "assert_macros.svh"

module matrix3_inverse_unit #(
   parameter int FRAC_BITS  = m3i_pkg::FRAC_BITS_DEF,
   parameter int FIFO_DEPTH = m3i_pkg::FIFO_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  m3i_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output m3i_pkg::rsp_type   rsp_data
);

   logic               work_valid;
   m3i_pkg::work_type  work_data;
   logic               fifo_full;
   logic               fifo_empty;
   logic               fifo_push;
   logic               back_pop;
   m3i_pkg::work_type  back_data;

   assign fifo_push = work_valid && !fifo_full;

   m3i_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_ok    (!fifo_full),
      .work_valid (work_valid),
      .work_data  (work_data)
   );

   m3i_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (work_data),
      .pop       (back_pop),
      .pop_data  (back_data),
      .full      (fifo_full),
      .empty     (fifo_empty)
   );

   m3i_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!fifo_empty),
      .in_data   (back_data),
      .in_pop    (back_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `ASSERT_SAME(a_singular_zero, clock, reset, rsp_valid && rsp_data.singular, rsp_data.b00 == '0 && rsp_data.b11 == '0 && rsp_data.b22 == '0, "singular result with nonzero elements")
   `ASSERT_NEXT(a_front_hold, clock, reset, work_valid && fifo_full, work_valid && $stable(work_data), "front end lost a beat while the queue was full")
   `ASSERT_SAME(a_pop_nonempty, clock, reset, back_pop, !fifo_empty, "queue popped while empty")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the 3x3 fixed-point matrix inverse unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [191:0] wide_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 80;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   m3i_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   m3i_pkg::rsp_type rsp_data;

   m3i_pkg::req_type matrices_pending[$];
   m3i_pkg::rsp_type inverses_due[$];
   int      send_idle_pct;
   int      recv_stall_pct;
   logic    recv_hold;
   int      mismatches = 0;
   int      quiet_cycles = 0;

   matrix3_inverse_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] scaled_ratio(wide_type cof, wide_type det);
      wide_type num;
      wide_type den;
      wide_type quo;
      logic     neg;
      neg = cof[191] ^ det[191];
      num = cof[191] ? -cof : cof;
      den = det[191] ? -det : det;
      quo = ((num <<< (2 * m3i_pkg::FRAC_BITS_DEF + 1)) + den) / (den <<< 1);
      if (neg) begin
         if (quo > (wide_type'(1) <<< (m3i_pkg::DATA_W - 1)))
            quo = wide_type'(1) <<< (m3i_pkg::DATA_W - 1);
         quo = -quo;
      end else if (quo > (wide_type'(1) <<< (m3i_pkg::DATA_W - 1)) - 1) begin
         quo = (wide_type'(1) <<< (m3i_pkg::DATA_W - 1)) - 1;
      end
      return quo[31:0];
   endfunction

   function automatic m3i_pkg::rsp_type invert_matrix(m3i_pkg::req_type m);
      logic [m3i_pkg::DATA_W*9-1:0] flat;
      wide_type            e[9];
      wide_type            det;
      wide_type            cof;
      logic [31:0]         b[9];
      int                  pairs[9][4];
      int                  i;
      pairs = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
                '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
                '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
      flat = m;
      for (i = 0; i < 9; i++)
         e[i] = $signed(flat[m3i_pkg::DATA_W*(9-i)-1 -: m3i_pkg::DATA_W]);
      det = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[2] * e[3] * e[7]
          - e[2] * e[4] * e[6] - e[1] * e[3] * e[8] - e[0] * e[5] * e[7];
      if (det == 0) return '{singular: 1'b1, default: '0};
      for (i = 0; i < 9; i++) begin
         cof  = e[pairs[i][0]] * e[pairs[i][1]] - e[pairs[i][2]] * e[pairs[i][3]];
         b[i] = scaled_ratio(cof, det);
      end
      return {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8], 1'b0};
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", field, got, want);
      mismatches++;
   endtask

   function automatic logic [31:0] pick_element(int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(2 ** 19) - 2 ** 18;
         2: return $urandom_range(511) - 256;
         default: return $urandom_range(2 ** 25) - 2 ** 24;
      endcase
   endfunction

   function automatic m3i_pkg::req_type random_matrix();
      logic [31:0] e[9];
      int          kind;
      int          i;
      int          shape;
      shape = $urandom_range(99);
      kind  = shape < 20 ? 0 : (shape < 75 ? 1 : (shape < 85 ? 2 : 3));
      for (i = 0; i < 9; i++) e[i] = pick_element(kind);
      if ($urandom_range(9) == 0) begin
         e[6] = e[0];
         e[7] = e[1];
         e[8] = e[2];
      end
      return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
   endfunction

   task automatic load_directed();
      logic [31:0] one;
      logic [31:0] mx;
      logic [31:0] mn;
      one = 32'h0001_0000;
      mx  = 32'h7fff_ffff;
      mn  = 32'h8000_0000;
      matrices_pending.push_back({one, 32'h0, 32'h0, 32'h0, one, 32'h0, 32'h0, 32'h0, one});
      matrices_pending.push_back('0);
      matrices_pending.push_back({9{mx}});
      matrices_pending.push_back({9{mn}});
      matrices_pending.push_back({mx, 32'h0, 32'h0, 32'h0, mx, 32'h0, 32'h0, 32'h0, mx});
      matrices_pending.push_back({mn, 32'h0, 32'h0, 32'h0, mn, 32'h0, 32'h0, 32'h0, mn});
      matrices_pending.push_back({mx, mn, 32'h0, 32'h0, mx, mn, mn, 32'h0, mx});
      matrices_pending.push_back({32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0,
                                  32'h0, 32'h0, 32'h1});
      matrices_pending.push_back({32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0,
                                  32'h0, 32'h0, 32'h1});
      matrices_pending.push_back({32'h0002_0000, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0,
                                  32'h0, 32'h0, 32'hfffc_0000});
      matrices_pending.push_back({32'h0, one, 32'h0, one, 32'h0, 32'h0, 32'h0, 32'h0, one});
      matrices_pending.push_back({32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                  32'h0002_0000, 32'h0004_0000, 32'h0006_0000,
                                  32'h0001_0000, 32'h0, 32'h0001_0000});
      matrices_pending.push_back({one, 32'h0002_0000, 32'h0003_0000,
                                  32'h0, one, 32'h0004_0000,
                                  32'h0005_0000, 32'h0006_0000, 32'h0});
      matrices_pending.push_back({32'h3, 32'h0, 32'h0, 32'h0, 32'h3, 32'h0,
                                  32'h0, 32'h0, 32'h3});
      matrices_pending.push_back({32'h0000_8000, 32'hffff_8000, 32'h0, 32'h0000_8000,
                                  32'h0000_8000, 32'h0, 32'h0, 32'h0, 32'h0000_8000});
      matrices_pending.push_back({mx, mx, mx, mx, mx, mn, mn, mx, mx});
   endtask

   task automatic wait_drained();
      while (matrices_pending.size() != 0 || inverses_due.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) inverses_due.push_back(invert_matrix(req_data));
         if (!req_valid || !req_stall) begin
            if (matrices_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= matrices_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      m3i_pkg::rsp_type want;
      logic [288:0] g;
      logic [288:0] w;
      int i;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (inverses_due.size() == 0) begin
               report_mismatch("unexpected result beat", rsp_data.b00, 32'h0);
            end else begin
               want = inverses_due.pop_front();
               g = rsp_data;
               w = want;
               for (i = 0; i < 9; i++)
                  if (g[288-32*i -: 32] !== w[288-32*i -: 32])
                     report_mismatch($sformatf("b%0d%0d", i / 3, i % 3),
                                     g[288-32*i -: 32], w[288-32*i -: 32]);
               if (rsp_data.singular !== want.singular)
                  report_mismatch("singular", {31'b0, rsp_data.singular},
                                  {31'b0, want.singular});
            end
         end
         rsp_stall <= recv_hold || ($urandom_range(99) < recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      reset          = 1'b1;
      recv_hold      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      load_directed();
      wait_drained();
      recv_hold <= 1'b1;
      for (n = 0; n < 100; n++) matrices_pending.push_back(random_matrix());
      repeat (300) @(posedge clock);
      recv_hold <= 1'b0;
      wait_drained();
      for (phase = 0; phase < 8; phase++) begin
         send_idle_pct  = (phase % 4 == 1 || phase % 4 == 3) ? 50 : 0;
         recv_stall_pct = (phase % 4 == 2) ? 50 : 0;
         if (phase % 4 == 3) begin
            send_idle_pct  = 16;
            recv_stall_pct = 16;
         end
         for (n = 0; n < 140; n++) matrices_pending.push_back(random_matrix());
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
